### hdl/fbs_pkg.sv
// Shared types and constants for the fraction-to-boundary step block.
package fbs_pkg;

    localparam int DATA_W  = 32;
    localparam int ALPHA_W = 24;
    localparam int OUT_W   = 24;
    localparam int NUM_W   = ALPHA_W + DATA_W - 1;

    localparam logic [ALPHA_W-1:0] ALPHA_RST = 24'd8346648;

    // register index decoded from paddr[2]
    localparam logic REG_DAMPING = 1'b0;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_CHK  = 6'b000100,
        S_DIV  = 6'b001000,
        S_UPD  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic chk;
        logic div_step;
        logic upd;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic zero;
        logic sat;
        logic div_done;
        logic last;
        logic out_free;
    } t_sts;

endpackage

### hdl/fbs_ctrl.sv
// Sequencer for the fraction-to-boundary step block.
module fbs_ctrl import fbs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_MUL;
            end
            S_MUL: begin
                if (i_sts.skip || i_sts.zero) n_state = S_UPD;
                else n_state = S_CHK;
            end
            S_CHK: begin
                if (i_sts.sat) n_state = S_UPD;
                else n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_UPD;
            end
            S_UPD: begin
                if (i_sts.last) n_state = S_OUT;
                else n_state = S_IDLE;
            end
            S_OUT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_cmd.load     = (r_state == S_IDLE) && i_valid;
    assign o_cmd.mul      = (r_state == S_MUL);
    assign o_cmd.chk      = (r_state == S_CHK);
    assign o_cmd.div_step = (r_state == S_DIV);
    assign o_cmd.upd      = (r_state == S_UPD);
    assign o_cmd.emit     = (r_state == S_OUT) && i_sts.out_free;

endmodule

### hdl/fbs_dp.sv
// Datapath: operand capture, multiplier, restoring divider, running minimum, output register.
module fbs_dp import fbs_pkg::*; #(
    parameter int FRAC_BITS = 23
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [ALPHA_W-1:0]       i_alpha,
    input  logic signed [DATA_W-1:0] i_current_value,
    input  logic signed [DATA_W-1:0] i_direction,
    input  logic                     i_last_element,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic [OUT_W-1:0]         o_step_length
);

    localparam int MW    = FRAC_BITS + 1;
    localparam int QW    = FRAC_BITS + 2;
    localparam int REM_W = (NUM_W > DATA_W + QW) ? NUM_W : DATA_W + QW;
    localparam int CNT_W = $clog2(QW);

    localparam logic [MW-1:0] ONE_MW = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [QW-1:0] ONE_QW = {2'b01, {FRAC_BITS{1'b0}}};

    logic signed [DATA_W-1:0] r_v;
    logic signed [DATA_W-1:0] r_d;
    logic [DATA_W-1:0]        r_magd;
    logic                     r_last;
    logic [NUM_W-1:0]         r_num;
    logic [REM_W-1:0]         r_rem;
    logic [REM_W-1:0]         r_dvs;
    logic [QW-1:0]            r_q;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_sat;
    logic [MW-1:0]            r_min;
    logic                     r_o_valid;
    logic [OUT_W-1:0]         r_o_step;

    logic [NUM_W-1:0]   w_prod;
    logic [REM_W-1:0]   w_ovf_lim;
    logic               w_ovf;
    logic               w_ge;
    logic [REM_W-1:0]   w_diff;
    logic [MW-1:0]      w_cand;
    logic               w_skip;
    logic               w_zero;
    logic [MW+OUT_W-1:0] w_ext;

    assign w_skip    = !r_d[DATA_W-1];
    assign w_zero    = r_v[DATA_W-1] || (r_v == '0);
    assign w_prod    = i_alpha * r_v[DATA_W-2:0];
    assign w_ovf_lim = REM_W'(r_magd) << QW;
    assign w_ovf     = REM_W'(r_num) >= w_ovf_lim;
    assign w_ge      = r_rem >= r_dvs;
    assign w_diff    = r_rem - r_dvs;
    assign w_ext     = {{OUT_W{1'b0}}, r_min};

    always_comb begin
        if (w_zero) begin
            w_cand = '0;
        end else if (r_sat || (r_q > ONE_QW)) begin
            w_cand = ONE_MW;
        end else begin
            w_cand = r_q[MW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v    <= i_current_value;
            r_d    <= i_direction;
            r_magd <= (~i_direction) + DATA_W'(1);
            r_last <= i_last_element;
        end
        if (i_cmd.mul) begin
            r_num <= w_prod;
        end
        if (i_cmd.chk) begin
            r_rem <= REM_W'(r_num);
            r_dvs <= REM_W'(r_magd) << (QW - 1);
            r_cnt <= CNT_W'(QW - 1);
            r_sat <= w_ovf;
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            if (w_ge) r_rem <= w_diff;
            r_dvs <= r_dvs >> 1;
            r_q   <= {r_q[QW-2:0], w_ge};
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.emit) begin
            r_o_step <= w_ext[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min     <= ONE_MW;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_min <= ONE_MW;
            end else if (i_cmd.upd && !w_skip && (w_cand < r_min)) begin
                r_min <= w_cand;
            end
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_sts.skip     = w_skip;
    assign o_sts.zero     = w_zero;
    assign o_sts.sat      = w_ovf;
    assign o_sts.div_done = (r_cnt == '0);
    assign o_sts.last     = r_last;
    assign o_sts.out_free = !r_o_valid || i_out_ready;

    assign o_out_valid   = r_o_valid;
    assign o_step_length = r_o_step;

endmodule

### hdl/fraction_to_boundary_step_core.sv
// Top level of the fraction-to-boundary step block: register port, sequencer and datapath.
//
// Input channel (i_valid / o_ready) takes one (value, direction, last) beat per element.
// Output channel (o_valid / i_ready) gives one step_length beat per vector, after the
// beat marked last. The result is the smallest clamped ratio -alpha*value/direction over
// the elements with negative direction, 1.0 if there are none.
// Per element: accept, multiply, range check, FRAC_BITS+2 restoring divider steps and an
// update. Elements with direction >= 0 or value <= 0 skip the divider, and so does an
// element whose quotient is found too large at the range check. The last element adds
// an output state that loads the output register. The divider produces one quotient bit
// per cycle and sets the rate while the output is not held by the receiver. One element
// is in work at a time.
// The output register holds a finished result while the next elements stream in; a
// second result waits in the sequencer until the receiver takes the first.
// Reset (synchronous, active low) empties the output, sets the running minimum to 1.0
// and the damping factor to about 0.995. Write the damping factor only while idle.
module fraction_to_boundary_step_core import fbs_pkg::*; #(
    parameter int FRAC_BITS = 23
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [DATA_W-1:0] i_current_value,
    input  logic signed [DATA_W-1:0] i_direction,
    input  logic                     i_last_element,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [OUT_W-1:0]         o_step_length
);

    logic [ALPHA_W-1:0] r_alpha;
    t_cmd               w_cmd;
    t_sts               w_sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RST;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DAMPING)) begin
            r_alpha <= pwdata[ALPHA_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_DAMPING) ? {{(32 - ALPHA_W){1'b0}}, r_alpha} : '0;

    fbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    fbs_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_alpha         (r_alpha),
        .i_current_value (i_current_value),
        .i_direction     (i_direction),
        .i_last_element  (i_last_element),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_out_ready     (i_ready),
        .o_out_valid     (o_valid),
        .o_step_length   (o_step_length)
    );

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input accepted while an element is in work");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("block not empty after reset");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({8'b0, o_step_length} <= (32'd1 << FRAC_BITS)))
        else $error("step length above 1.0");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.mul, w_cmd.chk, w_cmd.div_step, w_cmd.upd, w_cmd.emit}))
        else $error("sequencer issued overlapping commands");

endmodule

### verif/fraction_to_boundary_step_core_tb.sv
// Self-checking testbench for the fraction-to-boundary step core: stream driver, step monitor.
`timescale 1ns / 1ps

module fraction_to_boundary_step_core_tb import fbs_pkg::*;;

    localparam logic [OUT_W-1:0] UNIT = 24'h800000;
    localparam logic [2:0] DAMPING_ADDR = {REG_DAMPING, 2'b00};
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES = 3000;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic [DATA_W-1:0] dir;
        logic              last;
    } t_elem;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [2:0]               paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic signed [DATA_W-1:0] i_current_value = '0;
    logic signed [DATA_W-1:0] i_direction = '0;
    logic                     i_last_element = 1'b0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic [OUT_W-1:0]         o_step_length;

    t_elem            pending_elems[$];
    logic [OUT_W-1:0] expected_steps[$];
    logic [ALPHA_W-1:0] damping_now = ALPHA_RST;
    logic [OUT_W-1:0]   run_min = UNIT;

    int elems_queued = 0;
    int elems_taken = 0;
    int steps_seen = 0;
    int errors = 0;
    int idle_cycles = 0;
    int gap_left = 0;
    int burst_left = 0;
    int hold_left = 0;
    bit hold_done = 0;
    int ready_mode = 0;
    int mode_left = 0;
    int pat_cnt = 0;

    fraction_to_boundary_step_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_current_value (i_current_value),
        .i_direction     (i_direction),
        .i_last_element  (i_last_element),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_step_length   (o_step_length)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // clamped -alpha*v/d for a negative direction
    function automatic logic [OUT_W-1:0] boundary_ratio(input logic [DATA_W-1:0] v,
                                                         input logic [DATA_W-1:0] d,
                                                         input logic [ALPHA_W-1:0] a);
        logic [55:0] num;
        logic [55:0] mag;
        logic [55:0] q;
        if (v[DATA_W-1] || v == '0)
            return '0;
        mag = 56'({1'b0, ~d} + 33'd1);
        num = 56'(a) * 56'(v);
        q = num / mag;
        return (q > 56'(UNIT)) ? UNIT : q[OUT_W-1:0];
    endfunction

    task automatic absorb_element(input t_elem e);
        logic [OUT_W-1:0] cand;
        if (e.dir[DATA_W-1]) begin
            cand = boundary_ratio(e.val, e.dir, damping_now);
            if (cand < run_min)
                run_min = cand;
        end
        if (e.last) begin
            expected_steps.push_back(run_min);
            run_min = UNIT;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic push_elem(input logic [DATA_W-1:0] v, input logic [DATA_W-1:0] d,
                             input logic last);
        t_elem e;
        e.val = v;
        e.dir = d;
        e.last = last;
        pending_elems.push_back(e);
        elems_queued++;
    endtask

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return {1'b1, 31'($urandom)};
            2: return $urandom;
            default: return $urandom >> $urandom_range(1, 31);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_dir(input logic [DATA_W-1:0] v);
        case ($urandom_range(0, 11))
            0: return '0;
            1: return $urandom >> $urandom_range(1, 31);
            2: return 32'h80000000;
            3: return $urandom;
            4, 5: return -(v + 32'($urandom_range(0, 64)) - 32'd32);
            6, 7: return -(v << $urandom_range(0, 4));
            default: return -(($urandom >> $urandom_range(1, 31)) + 32'd1);
        endcase
    endfunction

    task automatic push_rand_vector();
        int n;
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 19))
            0: n = $urandom_range(21, 60);
            1, 2, 3: n = $urandom_range(7, 20);
            default: n = $urandom_range(1, 6);
        endcase
        for (int k = 0; k < n; k++) begin
            v = rand_value();
            push_elem(v, rand_dir(v), k == n - 1);
        end
    endtask

    task automatic write_damping(input logic [ALPHA_W-1:0] a);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= DAMPING_ADDR;
        pwdata <= 32'(a);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        damping_now = a;
    endtask

    task automatic wait_drained();
        while (elems_taken != elems_queued || expected_steps.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // sender: bursts of beats separated by random gaps
    always @(posedge i_clk) begin : drive_elems
        t_elem nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                nxt.val = i_current_value;
                nxt.dir = i_direction;
                nxt.last = i_last_element;
                absorb_element(nxt);
                elems_taken++;
            end
            if (!i_valid || o_ready) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
                end
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_elems.size() != 0) begin
                    nxt = pending_elems.pop_front();
                    i_valid <= 1'b1;
                    i_current_value <= nxt.val;
                    i_direction <= nxt.dir;
                    i_last_element <= nxt.last;
                    burst_left--;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (!hold_done && steps_seen >= 20) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
            i_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            pat_cnt++;
            case (ready_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= 1'($urandom_range(0, 1));
                2: i_ready <= ($urandom_range(0, 7) == 0);
                default: i_ready <= (pat_cnt % 5 != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : check_steps
        logic [OUT_W-1:0] want;
        if (i_rst_n && o_valid && i_ready) begin
            steps_seen++;
            if (expected_steps.size() == 0) begin
                report_mismatch($sformatf("step_length %0d with no vector pending",
                                          o_step_length));
            end else begin
                want = expected_steps.pop_front();
                if (o_step_length !== want)
                    report_mismatch($sformatf("step_length %0d, expected %0d",
                                              o_step_length, want));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable && pwrite))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("ERROR: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic [ALPHA_W-1:0] alphas[9];
        alphas[0] = ALPHA_RST;
        alphas[1] = '0;
        alphas[2] = UNIT;
        alphas[3] = 24'hFFFFFF;
        alphas[4] = 24'h000001;
        alphas[5] = 24'($urandom_range(0, 24'hFFFFFF));
        alphas[6] = 24'($urandom_range(0, 24'hFFFFFF));
        alphas[7] = 24'($urandom_range(24'h700000, 24'h800000));
        alphas[8] = 24'($urandom_range(24'h800001, 24'hFFFFFF));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed vectors under the reset damping factor
        push_elem(32'h00800000, 32'hFF800000, 1'b0);
        push_elem(32'h00400000, 32'h00000000, 1'b1);
        push_elem(32'd5, 32'd7, 1'b1);
        push_elem(32'h00000000, 32'hFFFFFFFF, 1'b1);
        push_elem(32'hFFFFFFFF, 32'hFFFFFFFB, 1'b0);
        push_elem(32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1);
        push_elem(32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1);
        push_elem(32'h00000001, 32'h80000000, 1'b1);
        push_elem(32'h80000000, 32'h80000000, 1'b1);
        push_elem(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
        push_elem(32'h7FFFFFFF, 32'h80000000, 1'b0);
        push_elem(32'h01800000, 32'hFE000000, 1'b1);
        push_elem(32'h00200000, 32'hFF000000, 1'b0);
        push_elem(32'h00100000, 32'hFF000000, 1'b0);
        push_elem(32'h00300000, 32'hFF000000, 1'b1);
        push_elem(32'h00800000, 32'h00800000, 1'b0);
        push_elem(32'h00800000, 32'hFF7FFFFF, 1'b1);
        push_elem(32'h55555555, 32'hAAAAAAAA, 1'b1);
        push_elem(32'h2AAAAAAA, 32'hD5555555, 1'b1);
        wait_drained();

        foreach (alphas[p]) begin
            write_damping(alphas[p]);
            if (p == 3) begin
                push_elem(32'h7FFFFFFF, 32'hFFFFFFFF, 1'b0);
                push_elem(32'h7FFFFFFF, 32'h80000000, 1'b1);
                push_elem(32'h00800000, 32'hFF800000, 1'b1);
            end
            while (elems_queued < 20 + (p + 1) * 192)
                push_rand_vector();
            wait_drained();
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
